FILE: design/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// shared constants for the sphere versus box contact unit
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int NORMAL_WIDTH = 16;
    localparam int AXES         = 3;

endpackage

FILE: design/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_if
// channel interfaces: input pair, classified item, contact result
// ----------------------------------------------------------------------------
interface sbc_in_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic        [CW-2:0] radius;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;

    modport source (output valid, center_x, center_y, center_z, radius,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    input ready);
    modport sink (input valid, center_x, center_y, center_z, radius,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  output ready);
endinterface

interface sbc_cls_if #(parameter int CW = 32);
    logic                  valid;
    logic                  ready;
    logic                  colliding;
    logic                  center_in;
    logic [2:0][CW-1:0]    mag;
    logic [2:0]            neg;
    logic [CW-2:0]         radius;
    logic [2*CW-3:0]       dist_sq;

    modport source (output valid, colliding, center_in, mag, neg, radius, dist_sq,
                    input ready);
    modport sink (input valid, colliding, center_in, mag, neg, radius, dist_sq,
                  output ready);
endinterface

interface sbc_out_if #(parameter int CW = 32, parameter int NW = 16);
    logic                 valid;
    logic                 ready;
    logic                 colliding;
    logic                 center_inside;
    logic        [CW-2:0] penetration;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
    logic signed [CW-1:0] contact_z;

    modport source (output valid, colliding, center_inside, penetration,
                    normal_x, normal_y, normal_z, contact_x, contact_y, contact_z,
                    input ready);
    modport sink (input valid, colliding, center_inside, penetration,
                  normal_x, normal_y, normal_z, contact_x, contact_y, contact_z,
                  output ready);
endinterface

FILE: design/sbc_front.sv
// ----------------------------------------------------------------------------
// sbc_front
// clamp, squared distance and collision classification, three stages
// ----------------------------------------------------------------------------
module sbc_front import sbc_pkg::*; #(
    parameter int CW = COORD_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbc_in_if.sink     i_item,
    sbc_cls_if.source  o_cls
);

    logic signed [CW-1:0] c_in  [AXES];
    logic signed [CW-1:0] lo_in [AXES];
    logic signed [CW-1:0] hi_in [AXES];
    logic [CW-1:0]        n_mag [AXES];
    logic [AXES-1:0]      n_neg;
    logic                 adv;

    logic                 r_v1, r_v2, r_v3;
    logic [CW-1:0]        r_mag1 [AXES];
    logic [AXES-1:0]      r_neg1;
    logic [CW-2:0]        r_rad1;
    logic [2*CW-1:0]      r_sq2 [AXES];
    logic [2*CW-3:0]      r_rsq2;
    logic [CW-1:0]        r_mag2 [AXES];
    logic [AXES-1:0]      r_neg2;
    logic [CW-2:0]        r_rad2;
    logic [2*CW+1:0]      n_sum;
    logic                 r_coll3, r_inside3;
    logic [2*CW-3:0]      r_dsq3;
    logic [2:0][CW-1:0]   r_mag3;
    logic [AXES-1:0]      r_neg3;
    logic [CW-2:0]        r_rad3;

    assign c_in[0]  = i_item.center_x;
    assign c_in[1]  = i_item.center_y;
    assign c_in[2]  = i_item.center_z;
    assign lo_in[0] = i_item.box_min_x;
    assign lo_in[1] = i_item.box_min_y;
    assign lo_in[2] = i_item.box_min_z;
    assign hi_in[0] = i_item.box_max_x;
    assign hi_in[1] = i_item.box_max_y;
    assign hi_in[2] = i_item.box_max_z;

    assign adv          = !r_v3 || o_cls.ready;
    assign i_item.ready = adv;

    // clamp into the box, lower bound wins on an inverted box
    always_comb begin
        logic signed [CW:0] c, lo, hi, p, dl;
        for (int a = 0; a < AXES; a++) begin
            c  = {c_in[a][CW-1], c_in[a]};
            lo = {lo_in[a][CW-1], lo_in[a]};
            hi = {hi_in[a][CW-1], hi_in[a]};
            p  = (c < hi) ? c : hi;
            if (lo > p) begin
                p = lo;
            end
            dl = c - p;
            n_neg[a] = dl[CW];
            n_mag[a] = dl[CW] ? CW'(-dl) : CW'(dl);
        end
    end

    assign n_sum = {2'b00, r_sq2[0]} + {2'b00, r_sq2[1]} + {2'b00, r_sq2[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_item.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < AXES; a++) begin
                r_mag1[a] <= n_mag[a];
                r_sq2[a]  <= r_mag1[a] * r_mag1[a];
                r_mag2[a] <= r_mag1[a];
                r_mag3[a] <= r_mag2[a];
            end
            r_neg1    <= n_neg;
            r_rad1    <= i_item.radius;
            r_rsq2    <= r_rad1 * r_rad1;
            r_neg2    <= r_neg1;
            r_rad2    <= r_rad1;
            r_coll3   <= n_sum < {4'b0000, r_rsq2};
            r_inside3 <= n_sum == '0;
            r_dsq3    <= n_sum[2*CW-3:0];
            r_neg3    <= r_neg2;
            r_rad3    <= r_rad2;
        end
    end

    assign o_cls.valid     = r_v3;
    assign o_cls.colliding = r_coll3;
    assign o_cls.center_in = r_inside3;
    assign o_cls.mag       = r_mag3;
    assign o_cls.neg       = r_neg3;
    assign o_cls.radius    = r_rad3;
    assign o_cls.dist_sq   = r_dsq3;

endmodule

FILE: design/sbc_queue.sv
// ----------------------------------------------------------------------------
// sbc_queue
// short fifo between classification and the contact pipeline
// ----------------------------------------------------------------------------
module sbc_queue import sbc_pkg::*; #(
    parameter int CW = COORD_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbc_cls_if.sink    i_cls,
    sbc_cls_if.source  o_cls
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic               colliding;
        logic               center_in;
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic [CW-2:0]      radius;
        logic [2*CW-3:0]    dist_sq;
    } t_entry;

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          push, pop;
    t_entry        head;

    assign i_cls.ready = r_cnt != (AW+1)'(DEPTH);
    assign push        = i_cls.valid && i_cls.ready;
    assign pop         = o_cls.ready && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{colliding: i_cls.colliding, center_in: i_cls.center_in,
                             mag: i_cls.mag, neg: i_cls.neg,
                             radius: i_cls.radius, dist_sq: i_cls.dist_sq};
        end
    end

    assign head            = r_mem[r_rd];
    assign o_cls.valid     = r_cnt != '0;
    assign o_cls.colliding = head.colliding;
    assign o_cls.center_in = head.center_in;
    assign o_cls.mag       = head.mag;
    assign o_cls.neg       = head.neg;
    assign o_cls.radius    = head.radius;
    assign o_cls.dist_sq   = head.dist_sq;

endmodule

FILE: design/sbc_back.sv
// ----------------------------------------------------------------------------
// sbc_back
// square root, normal division and contact scaling, one bit per stage
// ----------------------------------------------------------------------------
module sbc_back import sbc_pkg::*; #(
    parameter int CW = COORD_WIDTH,
    parameter int NW = NORMAL_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbc_cls_if.sink    i_cls,
    sbc_out_if.source  o_result
);

    localparam int NF    = NW - 1;
    localparam int DW    = CW + NW;
    localparam int SQ_N  = CW - 1;
    localparam int DV0   = SQ_N + 1;
    localparam int DV_N  = NW;
    localparam int MUL   = DV0 + DV_N + 1;
    localparam logic [NW-1:0] NMAX = NW'((1 << NF) - 1);

    typedef struct packed {
        logic               v;
        logic               coll;
        logic               center_in;
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic [CW-2:0]      rad;
        logic [2*CW-3:0]    rem;
        logic [CW-2:0]      root;
        logic [2:0][DW-1:0] drem;
        logic [2:0][NW-1:0] q;
        logic [2:0][CW-1:0] cm;
    } t_bk;

    t_bk   r_bk [MUL+1];
    t_bk   n_bk [MUL+1];
    logic  adv;
    logic  r_out_v;
    logic  r_coll, r_inside;
    logic [CW-2:0]        r_pen;
    logic signed [NW-1:0] r_nrm [AXES];
    logic signed [CW-1:0] r_con [AXES];

    assign adv         = !r_out_v || o_result.ready;
    assign i_cls.ready = adv;

    always_comb begin
        n_bk[0]           = '0;
        n_bk[0].v         = i_cls.valid;
        n_bk[0].coll      = i_cls.colliding;
        n_bk[0].center_in = i_cls.center_in;
        n_bk[0].mag       = i_cls.mag;
        n_bk[0].neg       = i_cls.neg;
        n_bk[0].rad       = i_cls.radius;
        n_bk[0].rem       = i_cls.dist_sq;
    end

    for (genvar k = 1; k <= MUL; k++) begin : g_stage
        if (k <= SQ_N) begin : g_sqrt
            localparam int B = CW - 1 - k;
            always_comb begin
                logic [2*CW-1:0] t;
                n_bk[k] = r_bk[k-1];
                t = ({{(CW+1){1'b0}}, r_bk[k-1].root} << (B + 1))
                    | ((2*CW)'(1) << (2 * B));
                if ({2'b00, r_bk[k-1].rem} >= t) begin
                    n_bk[k].rem  = r_bk[k-1].rem - t[2*CW-3:0];
                    n_bk[k].root = r_bk[k-1].root | ((CW-1)'(1) << B);
                end
            end
        end else if (k == DV0) begin : g_dprep
            always_comb begin
                n_bk[k] = r_bk[k-1];
                for (int a = 0; a < AXES; a++) begin
                    n_bk[k].drem[a] = ({{NW{1'b0}}, r_bk[k-1].mag[a]} << NF)
                                      + DW'(r_bk[k-1].root >> 1);
                    n_bk[k].q[a]    = '0;
                end
            end
        end else if (k < MUL) begin : g_div
            localparam int J = NF - (k - DV0 - 1);
            always_comb begin
                logic [DW-1:0] dd;
                n_bk[k] = r_bk[k-1];
                dd = {{(NW+1){1'b0}}, r_bk[k-1].root} << J;
                for (int a = 0; a < AXES; a++) begin
                    if (r_bk[k-1].drem[a] >= dd) begin
                        n_bk[k].drem[a] = r_bk[k-1].drem[a] - dd;
                        n_bk[k].q[a]    = r_bk[k-1].q[a] | (NW'(1) << J);
                    end
                end
            end
        end else begin : g_mul
            always_comb begin
                logic [NW-1:0]    nm;
                logic [NF+CW-1:0] prod;
                n_bk[k] = r_bk[k-1];
                for (int a = 0; a < AXES; a++) begin
                    nm = (r_bk[k-1].q[a] > NMAX) ? NMAX : r_bk[k-1].q[a];
                    prod = NF'(nm) * r_bk[k-1].rad + (NF+CW)'(1 << (NF - 1));
                    n_bk[k].q[a]  = nm;
                    n_bk[k].cm[a] = CW'(prod >> NF);
                end
            end
        end
    end

    for (genvar k = 0; k <= MUL; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bk[k].v <= 1'b0;
            end else if (adv) begin
                r_bk[k] <= n_bk[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_bk[MUL].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_coll   <= r_bk[MUL].coll;
            r_inside <= r_bk[MUL].center_in;
            r_pen    <= r_bk[MUL].coll ? r_bk[MUL].rad - r_bk[MUL].root : '0;
            for (int a = 0; a < AXES; a++) begin
                if (r_bk[MUL].coll && !r_bk[MUL].center_in) begin
                    r_nrm[a] <= r_bk[MUL].neg[a] ? -r_bk[MUL].q[a] : r_bk[MUL].q[a];
                    r_con[a] <= r_bk[MUL].neg[a] ? r_bk[MUL].cm[a] : -r_bk[MUL].cm[a];
                end else begin
                    r_nrm[a] <= '0;
                    r_con[a] <= '0;
                end
            end
        end
    end

    assign o_result.valid         = r_out_v;
    assign o_result.colliding     = r_coll;
    assign o_result.center_inside = r_inside;
    assign o_result.penetration   = r_pen;
    assign o_result.normal_x      = r_nrm[0];
    assign o_result.normal_y      = r_nrm[1];
    assign o_result.normal_z      = r_nrm[2];
    assign o_result.contact_x     = r_con[0];
    assign o_result.contact_y     = r_con[1];
    assign o_result.contact_z     = r_con[2];

endmodule

FILE: design/sphere_box_contact_unit.sv
// ----------------------------------------------------------------------------
// sphere_box_contact_unit
// sphere versus axis aligned box contact test in fixed point
//
// i_item carries one sphere/box pair (signed Q16.16 centre and bounds,
// unsigned radius), o_result one contact record; both are valid/ready
// channels and a transfer happens when valid and ready are both high.
// while o_result is taken, a pair is accepted every cycle and results
// leave in order, one per cycle. a pair passes through three front
// stages (clamp, squares, compare), the queue, a back input register, one
// stage per root bit of the distance square root, a divider set-up stage,
// one stage per quotient bit of the normal division, a scaling multiply
// and the output register.
// the front and the back pipeline are split by a four-entry queue, so the
// front keeps accepting while the back is held. when o_result is not taken
// the back pipeline holds, the queue fills, and then i_item.ready drops.
// reset clears all valid flags; nothing else needs clearing.
// ----------------------------------------------------------------------------
module sphere_box_contact_unit import sbc_pkg::*; #(
    parameter int COORD_W  = COORD_WIDTH,
    parameter int NORMAL_W = NORMAL_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbc_in_if.sink     i_item,
    sbc_out_if.source  o_result
);

    sbc_cls_if #(.CW(COORD_W)) cls_front ();
    sbc_cls_if #(.CW(COORD_W)) cls_back ();

    sbc_front #(.CW(COORD_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_cls   (cls_front)
    );

    sbc_queue #(.CW(COORD_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cls   (cls_front),
        .o_cls   (cls_back)
    );

    sbc_back #(.CW(COORD_W), .NW(NORMAL_W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cls    (cls_back),
        .o_result (o_result)
    );

endmodule
